// File: hw/rtl/crc16fd_pkg.sv
// crc16fd_pkg: shared types, register codes, reset values and the crc-16 byte update
// for the framed packet receiver. No dependencies; used by every rtl file of the block.

package crc16fd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0]  HEADER_BYTE_RST = 8'hAA;
  localparam logic [7:0]  END_BYTE_RST    = 8'h55;
  localparam logic [15:0] CRC_PRESET_RST  = 16'hFFFF;
  localparam logic [7:0]  TWO_CMD_RST     = 8'h01;
  localparam logic [7:0]  THREE_CMD_RST   = 8'h02;
  localparam logic [15:0] CRC_POLY        = 16'h8005;

  localparam int PAYLOAD_DEPTH = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_BYTE    = 3'd0,
    CFG_END_BYTE       = 3'd1,
    CFG_CRC_PRESET     = 3'd2,
    CFG_TWO_BYTE_CMD   = 3'd3,
    CFG_THREE_BYTE_CMD = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_ADDR   = 3'd1,
    PH_CMD    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_HI = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_BAD_END = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  header_byte;
    logic [7:0]  end_byte;
    logic [15:0] crc_preset;
    logic [7:0]  two_cmd;
    logic [7:0]  three_cmd;
  } cfg_t;

  typedef struct packed {
    logic [7:0] address;
    logic [7:0] command;
    logic [7:0] pay0;
    logic [7:0] pay1;
    logic [7:0] pay2;
    logic [1:0] count;
    status_t    status;
  } res_t;

  // one byte into the crc, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/crc16_frame_deframer.sv
// crc16_frame_deframer: top level of the framed packet receiver with crc-16 check.
// Depends on crc16fd_pkg, crc16fd_parser and crc16fd_out_q.
//
//   channel | ports                                   | direction | moves
//   --------+-----------------------------------------+-----------+-----------------------
//   in      | in_valid, in_stall, in_rx_byte          | sink      | one received byte
//   out     | out_valid, out_stall, out_frame_*,      | source    | one completed frame
//           | out_payload_*, out_frame_status         |           |
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata         | sink      | register write
//
// one byte per cycle while in_stall is low; each byte is handled in the cycle it is accepted
// a frame result enters the output register in the cycle after its end byte is accepted
// when that register is free; under a stalled out side it waits in the skid entry
// rst_n is synchronous; it clears the parser to hunting and loads register defaults
// in_stall rises only when both result entries are full under a stalled out side

module crc16_frame_deframer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           out_frame_address,
  output logic [7:0]                           out_frame_command,
  output logic [7:0]                           out_payload_first,
  output logic [7:0]                           out_payload_second,
  output logic [7:0]                           out_payload_third,
  output logic [1:0]                           out_payload_count,
  output logic [1:0]                           out_frame_status,
  input  logic                                 cfg_wr_en,
  input  logic [crc16fd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [crc16fd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  crc16fd_pkg::cfg_t cfg_r, cfg_nxt;
  crc16fd_pkg::res_t res;
  crc16fd_pkg::res_t head;
  logic              res_vld;
  logic              q_full;
  logic              in_acc;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        crc16fd_pkg::CFG_HEADER_BYTE:    cfg_nxt.header_byte = cfg_wdata[7:0];
        crc16fd_pkg::CFG_END_BYTE:       cfg_nxt.end_byte    = cfg_wdata[7:0];
        crc16fd_pkg::CFG_CRC_PRESET:     cfg_nxt.crc_preset  = cfg_wdata;
        crc16fd_pkg::CFG_TWO_BYTE_CMD:   cfg_nxt.two_cmd     = cfg_wdata[7:0];
        crc16fd_pkg::CFG_THREE_BYTE_CMD: cfg_nxt.three_cmd   = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_byte <= crc16fd_pkg::HEADER_BYTE_RST;
      cfg_r.end_byte    <= crc16fd_pkg::END_BYTE_RST;
      cfg_r.crc_preset  <= crc16fd_pkg::CRC_PRESET_RST;
      cfg_r.two_cmd     <= crc16fd_pkg::TWO_CMD_RST;
      cfg_r.three_cmd   <= crc16fd_pkg::THREE_CMD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_stall = q_full;
  assign in_acc   = in_valid && !q_full;

  crc16fd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .res_vld (res_vld),
    .res     (res)
  );

  crc16fd_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .out_stall (out_stall),
    .head_vld  (out_valid),
    .head      (head),
    .full      (q_full)
  );

  assign out_frame_address  = head.address;
  assign out_frame_command  = head.command;
  assign out_payload_first  = head.pay0;
  assign out_payload_second = head.pay1;
  assign out_payload_third  = head.pay2;
  assign out_payload_count  = head.count;
  assign out_frame_status   = head.status;

  a_no_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc) |-> !res_vld)
    else $error("frame result without an accepted request");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_status == crc16fd_pkg::ST_OK ||
                   out_frame_status == crc16fd_pkg::ST_CRC_ERR ||
                   out_frame_status == crc16fd_pkg::ST_BAD_END) &&
                  (out_payload_count != 2'd1))
    else $error("result with impossible status or data count");

endmodule

// File: hw/rtl/crc16fd_parser.sv
// crc16fd_parser: frame parse state machine, running crc and held frame fields.
// Depends on crc16fd_pkg; one accepted byte per cycle, at most one result per byte.

module crc16fd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [7:0]          rx_byte,
  input  crc16fd_pkg::cfg_t   cfg,
  output logic                res_vld,
  output crc16fd_pkg::res_t   res
);

  crc16fd_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]  pidx_r, pidx_nxt;
  logic [1:0]  exp_cnt_r, exp_cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [7:0]  pay_r   [crc16fd_pkg::PAYLOAD_DEPTH];
  logic [7:0]  pay_nxt [crc16fd_pkg::PAYLOAD_DEPTH];
  logic [15:0] rcrc_r, rcrc_nxt;

  logic        hdr_hit;
  logic [1:0]  cmd_cnt;
  logic [1:0]  pidx_inc;
  logic [1:0]  widx;
  logic [15:0] crc_src;
  logic [15:0] crc_upd;

  assign hdr_hit  = (rx_byte == cfg.header_byte);
  assign cmd_cnt  = (rx_byte == cfg.two_cmd)   ? 2'd2 :
                    (rx_byte == cfg.three_cmd) ? 2'd3 : 2'd0;
  assign pidx_inc = pidx_r + 2'd1;
  assign widx     = (pidx_r == 2'd3) ? 2'd0 : pidx_r;
  // the preset enters the crc on the header byte
  assign crc_src  = (phase_r == crc16fd_pkg::PH_HUNT) ? cfg.crc_preset : crc_r;
  assign crc_upd  = crc16fd_pkg::crc_byte(crc_src, rx_byte);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (phase_r)
        crc16fd_pkg::PH_HUNT:   phase_nxt = hdr_hit ? crc16fd_pkg::PH_ADDR : crc16fd_pkg::PH_HUNT;
        crc16fd_pkg::PH_ADDR:   phase_nxt = crc16fd_pkg::PH_CMD;
        crc16fd_pkg::PH_CMD:    phase_nxt = (cmd_cnt != 2'd0) ? crc16fd_pkg::PH_DATA
                                                              : crc16fd_pkg::PH_CRC_HI;
        crc16fd_pkg::PH_DATA:   phase_nxt = (pidx_inc >= exp_cnt_r) ? crc16fd_pkg::PH_CRC_HI
                                                                    : crc16fd_pkg::PH_DATA;
        crc16fd_pkg::PH_CRC_HI: phase_nxt = crc16fd_pkg::PH_CRC_LO;
        crc16fd_pkg::PH_CRC_LO: phase_nxt = crc16fd_pkg::PH_END;
        crc16fd_pkg::PH_END:    phase_nxt = crc16fd_pkg::PH_HUNT;
        default:                phase_nxt = crc16fd_pkg::PH_HUNT;
      endcase
    end
  end

  // held fields and crc
  always_comb begin
    pidx_nxt    = pidx_r;
    exp_cnt_nxt = exp_cnt_r;
    crc_nxt     = crc_r;
    addr_nxt    = addr_r;
    cmd_nxt     = cmd_r;
    pay_nxt     = pay_r;
    rcrc_nxt    = rcrc_r;
    if (acc) begin
      unique case (phase_r)
        crc16fd_pkg::PH_HUNT: begin
          if (hdr_hit) begin
            crc_nxt  = crc_upd;
            pidx_nxt = 2'd0;
          end
        end
        crc16fd_pkg::PH_ADDR: begin
          addr_nxt = rx_byte;
          crc_nxt  = crc_upd;
        end
        crc16fd_pkg::PH_CMD: begin
          cmd_nxt     = rx_byte;
          crc_nxt     = crc_upd;
          exp_cnt_nxt = cmd_cnt;
          pidx_nxt    = 2'd0;
        end
        crc16fd_pkg::PH_DATA: begin
          pay_nxt[widx] = rx_byte;
          crc_nxt       = crc_upd;
          pidx_nxt      = pidx_inc;
        end
        crc16fd_pkg::PH_CRC_HI: rcrc_nxt = {rx_byte, 8'h00};
        crc16fd_pkg::PH_CRC_LO: rcrc_nxt = {rcrc_r[15:8], rx_byte};
        default: ;
      endcase
    end
  end

  // outputs
  always_comb begin
    res_vld     = acc && (phase_r == crc16fd_pkg::PH_END);
    res.address = addr_r;
    res.command = cmd_r;
    res.pay0    = (exp_cnt_r > 2'd0) ? pay_r[0] : 8'h00;
    res.pay1    = (exp_cnt_r > 2'd1) ? pay_r[1] : 8'h00;
    res.pay2    = (exp_cnt_r > 2'd2) ? pay_r[2] : 8'h00;
    res.count   = exp_cnt_r;
    if (rx_byte != cfg.end_byte) begin
      res.status = crc16fd_pkg::ST_BAD_END;
    end else if (crc_r != rcrc_r) begin
      res.status = crc16fd_pkg::ST_CRC_ERR;
    end else begin
      res.status = crc16fd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= crc16fd_pkg::PH_HUNT;
      pidx_r    <= 2'd0;
      exp_cnt_r <= 2'd0;
      crc_r     <= crc16fd_pkg::CRC_PRESET_RST;
    end else begin
      phase_r   <= phase_nxt;
      pidx_r    <= pidx_nxt;
      exp_cnt_r <= exp_cnt_nxt;
      crc_r     <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    cmd_r  <= cmd_nxt;
    pay_r  <= pay_nxt;
    rcrc_r <= rcrc_nxt;
  end

  a_data_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == crc16fd_pkg::PH_DATA) |-> (exp_cnt_r != 2'd0 && pidx_r < exp_cnt_r))
    else $error("data phase without a pending data byte");

  a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == crc16fd_pkg::PH_END) |=> (phase_r == crc16fd_pkg::PH_HUNT))
    else $error("parser did not return to hunting after a frame");

  a_cmd_len: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == crc16fd_pkg::PH_CMD) |=>
      (exp_cnt_r == 2'd0 || exp_cnt_r == 2'd2 || exp_cnt_r == 2'd3))
    else $error("illegal data length after command byte");

endmodule

// File: hw/rtl/crc16fd_out_q.sv
// crc16fd_out_q: two-entry result buffer (output register plus skid entry).
// Depends on crc16fd_pkg; lets the parser keep taking bytes while a result waits.

module crc16fd_out_q (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_vld,
  input  crc16fd_pkg::res_t   res,
  input  logic                out_stall,
  output logic                head_vld,
  output crc16fd_pkg::res_t   head,
  output logic                full
);

  logic              head_vld_r, head_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  crc16fd_pkg::res_t head_r, head_nxt;
  crc16fd_pkg::res_t skid_r, skid_nxt;
  logic              out_take;

  assign out_take = head_vld_r && !out_stall;

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (!head_vld_r || out_take) begin
      if (skid_vld_r) begin
        head_vld_nxt = 1'b1;
        head_nxt     = skid_r;
        skid_vld_nxt = res_vld;
        skid_nxt     = res;
      end else begin
        head_vld_nxt = res_vld;
        head_nxt     = res;
      end
    end else if (res_vld) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign head_vld = head_vld_r;
  assign head     = head_r;
  assign full     = skid_vld_r;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid entry holds a result while the output register is empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_take) |-> !res_vld)
    else $error("result arrived with both entries full");

  a_park_in_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (head_vld_r && !out_take && res_vld) |=> (skid_vld_r && head_vld_r))
    else $error("result lost while output register was stalled");

endmodule

// File: tb/crc16_frame_deframer_checker.sv
`timescale 1ns / 1ps
// crc16_frame_deframer_checker: snoops the byte, result and register ports of the deframer,
// tracks the parse and crc per accepted byte and compares every frame result field by field.
// Depends on crc16fd_pkg for the port widths, register codes, phases and result layout.

module crc16_frame_deframer_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [7:0]                         in_rx_byte,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [7:0]                         out_frame_address,
  input  logic [7:0]                         out_frame_command,
  input  logic [7:0]                         out_payload_first,
  input  logic [7:0]                         out_payload_second,
  input  logic [7:0]                         out_payload_third,
  input  logic [1:0]                         out_payload_count,
  input  logic [1:0]                         out_frame_status,
  input  logic                               cfg_wr_en,
  input  logic [crc16fd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [crc16fd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                 fail_count,
  output int                                 frames_owed
);

  // register copies, updated from the write port
  logic [7:0]  hdr_reg;
  logic [7:0]  end_reg;
  logic [15:0] preset_reg;
  logic [7:0]  two_reg;
  logic [7:0]  three_reg;

  // parse state of the frame being received
  crc16fd_pkg::phase_t parse_at;
  logic [1:0]  data_idx;
  logic [1:0]  data_len;
  logic [15:0] crc_run;
  logic [15:0] crc_rx;
  logic [7:0]  addr_hold;
  logic [7:0]  cmd_hold;
  logic [7:0]  data_hold [3];

  crc16fd_pkg::res_t frames_due [$];
  int   errs = 0;

  // bitwise lfsr form of the msb-first crc, one input bit per shift
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ crc16fd_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void compare_field(input string field, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want_v, got_v);
      errs++;
    end
  endfunction

  always @(posedge clk) begin : watch
    crc16fd_pkg::res_t frame;
    logic [7:0] b;
    if (!rst_n) begin
      hdr_reg    = crc16fd_pkg::HEADER_BYTE_RST;
      end_reg    = crc16fd_pkg::END_BYTE_RST;
      preset_reg = crc16fd_pkg::CRC_PRESET_RST;
      two_reg    = crc16fd_pkg::TWO_CMD_RST;
      three_reg  = crc16fd_pkg::THREE_CMD_RST;
      parse_at   = crc16fd_pkg::PH_HUNT;
      data_idx   = '0;
      data_len   = '0;
      crc_run    = crc16fd_pkg::CRC_PRESET_RST;
      crc_rx     = '0;
      addr_hold  = '0;
      cmd_hold   = '0;
      for (int i = 0; i < 3; i++) begin
        data_hold[i] = '0;
      end
      frames_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        b = in_rx_byte;
        case (parse_at)
          crc16fd_pkg::PH_HUNT: begin
            // anything but the header is dropped; preset is latched here
            if (b == hdr_reg) begin
              crc_run  = crc16_step(preset_reg, b);
              data_idx = '0;
              parse_at = crc16fd_pkg::PH_ADDR;
            end
          end
          crc16fd_pkg::PH_ADDR: begin
            addr_hold = b;
            crc_run   = crc16_step(crc_run, b);
            parse_at  = crc16fd_pkg::PH_CMD;
          end
          crc16fd_pkg::PH_CMD: begin
            cmd_hold = b;
            crc_run  = crc16_step(crc_run, b);
            // two-byte code wins when both codes are equal
            if (b == two_reg) begin
              data_len = 2'd2;
            end else if (b == three_reg) begin
              data_len = 2'd3;
            end else begin
              data_len = 2'd0;
            end
            data_idx = '0;
            parse_at = (data_len != 0) ? crc16fd_pkg::PH_DATA : crc16fd_pkg::PH_CRC_HI;
          end
          crc16fd_pkg::PH_DATA: begin
            data_hold[data_idx] = b;
            crc_run  = crc16_step(crc_run, b);
            data_idx = data_idx + 2'd1;
            if (data_idx >= data_len) begin
              parse_at = crc16fd_pkg::PH_CRC_HI;
            end
          end
          crc16fd_pkg::PH_CRC_HI: begin
            crc_rx[15:8] = b;
            parse_at     = crc16fd_pkg::PH_CRC_LO;
          end
          crc16fd_pkg::PH_CRC_LO: begin
            crc_rx[7:0] = b;
            parse_at    = crc16fd_pkg::PH_END;
          end
          crc16fd_pkg::PH_END: begin
            frame.address = addr_hold;
            frame.command = cmd_hold;
            frame.pay0    = (data_len > 0) ? data_hold[0] : 8'h00;
            frame.pay1    = (data_len > 1) ? data_hold[1] : 8'h00;
            frame.pay2    = (data_len > 2) ? data_hold[2] : 8'h00;
            frame.count   = data_len;
            // a wrong end byte outranks a crc mismatch
            if (b != end_reg) begin
              frame.status = crc16fd_pkg::ST_BAD_END;
            end else if (crc_run != crc_rx) begin
              frame.status = crc16fd_pkg::ST_CRC_ERR;
            end else begin
              frame.status = crc16fd_pkg::ST_OK;
            end
            frames_due.push_back(frame);
            parse_at = crc16fd_pkg::PH_HUNT;
          end
          default: parse_at = crc16fd_pkg::PH_HUNT;
        endcase
      end

      // a write takes effect from the next request on
      if (cfg_wr_en) begin
        case (cfg_index)
          crc16fd_pkg::CFG_HEADER_BYTE:    hdr_reg    = cfg_wdata[7:0];
          crc16fd_pkg::CFG_END_BYTE:       end_reg    = cfg_wdata[7:0];
          crc16fd_pkg::CFG_CRC_PRESET:     preset_reg = cfg_wdata;
          crc16fd_pkg::CFG_TWO_BYTE_CMD:   two_reg    = cfg_wdata[7:0];
          crc16fd_pkg::CFG_THREE_BYTE_CMD: three_reg  = cfg_wdata[7:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          $error("frame result with none expected: address 0x%0h command 0x%0h",
                 out_frame_address, out_frame_command);
          errs++;
        end else begin
          frame = frames_due.pop_front();
          compare_field("frame_address", 16'(frame.address), 16'(out_frame_address));
          compare_field("frame_command", 16'(frame.command), 16'(out_frame_command));
          compare_field("payload_first", 16'(frame.pay0), 16'(out_payload_first));
          compare_field("payload_second", 16'(frame.pay1), 16'(out_payload_second));
          compare_field("payload_third", 16'(frame.pay2), 16'(out_payload_third));
          compare_field("payload_count", 16'(frame.count), 16'(out_payload_count));
          compare_field("frame_status", 16'(frame.status), 16'(out_frame_status));
        end
      end
    end
    fail_count  <= errs;
    frames_owed <= frames_due.size();
  end

endmodule

// File: tb/tb_crc16_frame_deframer.sv
`timescale 1ns / 1ps
// tb_crc16_frame_deframer: drives bytes, register writes and result back-pressure into the
// deframer, prints the verdict. Depends on crc16fd_pkg, crc16_frame_deframer, its checker.

module tb_crc16_frame_deframer;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 170;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_BAD_END, FR_BAD_BOTH} flaw_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [7:0]                         in_rx_byte = 8'h00;
  logic                               out_valid;
  logic                               out_stall;
  logic [7:0]                         out_frame_address;
  logic [7:0]                         out_frame_command;
  logic [7:0]                         out_payload_first;
  logic [7:0]                         out_payload_second;
  logic [7:0]                         out_payload_third;
  logic [1:0]                         out_payload_count;
  logic [1:0]                         out_frame_status;
  logic                               cfg_wr_en = 1'b0;
  logic [crc16fd_pkg::CFG_IDX_W-1:0]  cfg_index = crc16fd_pkg::CFG_HEADER_BYTE;
  logic [crc16fd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int fail_count;
  int frames_owed;

  // register values as last written, used to build frames
  logic [7:0]  cur_hdr;
  logic [7:0]  cur_end;
  logic [15:0] cur_preset;
  logic [7:0]  cur_two;
  logic [7:0]  cur_three;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_granted = 0;
  int frame_items   = 0;

  crc16_frame_deframer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_address  (out_frame_address),
    .out_frame_command  (out_frame_command),
    .out_payload_first  (out_payload_first),
    .out_payload_second (out_payload_second),
    .out_payload_third  (out_payload_third),
    .out_payload_count  (out_payload_count),
    .out_frame_status   (out_frame_status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  crc16_frame_deframer_checker u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_frame_address  (out_frame_address),
    .out_frame_command  (out_frame_command),
    .out_payload_first  (out_payload_first),
    .out_payload_second (out_payload_second),
    .out_payload_third  (out_payload_third),
    .out_payload_count  (out_payload_count),
    .out_frame_status   (out_frame_status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .fail_count         (fail_count),
    .frames_owed        (frames_owed)
  );

  always #5 clk = ~clk;

  // result side: random stall, or a long hold-off when one is asked for
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_granted != holds_asked) begin
        holds_granted++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(7) == 0) ? cur_hdr : 8'($urandom);
  endfunction

  // one request on the byte channel, with an optional gap before it
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] d0, input logic [7:0] d1,
                            input logic [7:0] d2, input flaw_t flaw);
    logic [7:0]  frame_q [$];
    logic [15:0] crc;
    int          len;
    len = (cmd == cur_two) ? 2 : (cmd == cur_three) ? 3 : 0;
    frame_q = '{cur_hdr, addr, cmd};
    if (len > 0) begin
      frame_q.push_back(d0);
      frame_q.push_back(d1);
    end
    if (len > 2) begin
      frame_q.push_back(d2);
    end
    crc = cur_preset;
    foreach (frame_q[i]) begin
      crc = crc16fd_pkg::crc_byte(crc, frame_q[i]);
    end
    if (flaw == FR_BAD_CRC || flaw == FR_BAD_BOTH) begin
      crc = crc ^ (16'h0001 << $urandom_range(15));
    end
    frame_q.push_back(crc[15:8]);
    frame_q.push_back(crc[7:0]);
    if (flaw == FR_BAD_END || flaw == FR_BAD_BOTH) begin
      frame_q.push_back(cur_end ^ 8'($urandom_range(255, 1)));
    end else begin
      frame_q.push_back(cur_end);
    end
    foreach (frame_q[i]) begin
      send_byte(frame_q[i]);
    end
    frame_items += frame_q.size();
  endtask

  task automatic set_regs(input logic [7:0] h, input logic [7:0] e, input logic [15:0] p,
                          input logic [7:0] t2, input logic [7:0] t3);
    crc16fd_pkg::cfg_idx_t regs [5];
    logic [15:0]           vals [5];
    regs = '{crc16fd_pkg::CFG_HEADER_BYTE, crc16fd_pkg::CFG_END_BYTE,
             crc16fd_pkg::CFG_CRC_PRESET, crc16fd_pkg::CFG_TWO_BYTE_CMD,
             crc16fd_pkg::CFG_THREE_BYTE_CMD};
    vals = '{16'(h), 16'(e), p, 16'(t2), 16'(t3)};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_wr_en  <= 1'b0;
    cur_hdr    = h;
    cur_end    = e;
    cur_preset = p;
    cur_two    = t2;
    cur_three  = t3;
  endtask

  // stop sending, wait for every frame result, then let the parser settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int target);
    int         stop_at;
    int         pick;
    int         n;
    logic [7:0] cmd;
    flaw_t      flaw;
    stop_at = frame_items + target;
    while (frame_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // line noise; a stray header here starts a frame
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
      end else if (pick < 14) begin
        // cut-off frame, the following bytes land in its slots
        n = $urandom_range(4, 1);
        send_byte(cur_hdr);
        repeat (n) send_byte(rand_byte());
        frame_items += n + 1;
      end else begin
        pick = $urandom_range(99);
        cmd  = (pick < 35) ? cur_two : (pick < 70) ? cur_three :
               (pick < 90) ? 8'($urandom) : cur_hdr;
        pick = $urandom_range(99);
        flaw = (pick < 70) ? FR_GOOD : (pick < 80) ? FR_BAD_CRC :
               (pick < 90) ? FR_BAD_END : FR_BAD_BOTH;
        send_frame(rand_byte(), cmd, rand_byte(), rand_byte(), rand_byte(), flaw);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs(crc16fd_pkg::HEADER_BYTE_RST, crc16fd_pkg::END_BYTE_RST,
             crc16fd_pkg::CRC_PRESET_RST, crc16fd_pkg::TWO_CMD_RST,
             crc16fd_pkg::THREE_CMD_RST);
    // dropped while hunting
    send_byte(8'h00);
    send_byte(8'hFF);
    // header value carried as a data byte
    send_frame(8'hFF, cur_two, cur_hdr, 8'h00, 8'h00, FR_GOOD);
    // wrong end together with a crc mismatch
    send_frame(8'h00, cur_three, 8'hFF, 8'h80, 8'h7F, FR_BAD_BOTH);
    // header value as command, no data
    send_frame(cur_end, cur_hdr, 8'h00, 8'h00, 8'h00, FR_BAD_CRC);
    drain();

    set_regs(8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    send_idle_pct = 33;
    recv_idle_pct = 62;
    random_phase(PHASE_ITEMS);
    drain();

    // both command codes equal
    set_regs(8'h00, 8'hFF, 16'h0000, 8'hFF, 8'hFF);
    send_idle_pct = 62;
    recv_idle_pct = 33;
    random_phase(PHASE_ITEMS);
    drain();

    set_regs(8'hFF, 8'h00, 16'hFFFF, 8'h00, 8'h80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    random_phase(PHASE_ITEMS);
    drain();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
